// ===== rtl/core/ipq_pkg.sv =====
// ipq_pkg: shared constants, op codes and cell command types of the indexed priority queue
// no dependencies; used by the interfaces, ipq_cell, ipq_ctrl and indexed_priority_queue_top
package ipq_pkg;

	localparam int CAPACITY = 64;
	localparam int POS_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int ID_SPACE = 64;
	localparam int ID_W     = $clog2(ID_SPACE);
	localparam int KEY_W    = 32;
	localparam int OP_W     = 3;
	localparam int LIMIT_W  = 7;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64);

	typedef enum logic [OP_W-1:0] {
		OP_INSERT     = 3'd0,
		OP_INCREASE   = 3'd1,
		OP_DECREASE   = 3'd2,
		OP_REMOVE_MAX = 3'd3,
		OP_QUERY      = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_REMOVE
	} cell_op_t;

	typedef struct packed {
		logic [ID_W-1:0]         id;
		logic signed [KEY_W-1:0] key;
	} cell_data_t;

	typedef struct packed {
		cell_op_t                op;
		logic [POS_W-1:0]        pos;
		logic [ID_W-1:0]         id;
		logic signed [KEY_W-1:0] key;
		logic [CNT_W-1:0]        count;
	} cell_cmd_t;

	typedef struct packed {
		logic [POS_W-1:0]        pos;
		logic signed [KEY_W-1:0] key;
		logic [ID_W-1:0]         head_id;
		logic signed [KEY_W-1:0] head_key;
	} loc_t;

endpackage

// ===== rtl/core/ipq_req_if.sv =====
// ipq_req_if: request channel (valid/ready plus operation payload)
// depends on ipq_pkg
interface ipq_req_if;
	logic                            valid;
	logic                            ready;
	logic [ipq_pkg::OP_W-1:0]        op;
	logic [ipq_pkg::ID_W-1:0]        entry_id;
	logic signed [ipq_pkg::KEY_W-1:0] priority_req;

	modport source (output valid, output op, output entry_id, output priority_req, input ready);
	modport sink (input valid, input op, input entry_id, input priority_req, output ready);
endinterface

// ===== rtl/core/ipq_rsp_if.sv =====
// ipq_rsp_if: result channel (valid/ready plus result payload)
// depends on ipq_pkg
interface ipq_rsp_if;
	logic                             valid;
	logic                             ready;
	logic                             ok;
	logic [ipq_pkg::ID_W-1:0]         out_id;
	logic signed [ipq_pkg::KEY_W-1:0] out_priority;
	logic [ipq_pkg::CNT_W-1:0]        count;

	modport source (output valid, output ok, output out_id, output out_priority, output count,
		input ready);
	modport sink (input valid, input ok, input out_id, input out_priority, input count,
		output ready);
endinterface

// ===== rtl/core/indexed_priority_queue_top.sv =====
// indexed_priority_queue_top: chain of list cells, id lookup tree and sequencer
// depends on ipq_pkg, ipq_req_if, ipq_rsp_if, ipq_cell, ipq_ctrl
//
//   channel  dir  handshake        payload
//   req      in   valid/ready      op, entry_id, priority_req
//   rsp      out  valid/ready      ok, out_id, out_priority, count
//   cfg      in   cfg_we           cfg_wdata (id_limit)
//
// insert, remove_max, query and unknown ops: accept in idle, then decide and write the result
// increase/decrease: decide only for an absent id, decide and change when the new priority is not better,
// decide, change and reinsert on success (lookup, remove shift, insert shift)
// all cells shift in parallel; the id lookup is a combinational or-tree over the cells
// arst_n clears count and id map and sets the limit to LIMIT_RESET; cell contents need no reset
// req.ready drops while an op is in flight or the result register is full and not taken
module indexed_priority_queue_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [ipq_pkg::LIMIT_W-1:0] cfg_wdata,
	ipq_req_if.sink                     req,
	ipq_rsp_if.source                   rsp
);
	import ipq_pkg::*;

	cell_cmd_t           cmd;
	loc_t                loc;
	cell_data_t          data [CAPACITY];
	logic [CAPACITY-1:0] ge;
	logic [CAPACITY-1:0] match;

	ipq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.rsp       (rsp),
		.loc       (loc),
		.cmd       (cmd)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		cell_data_t prev_data;
		cell_data_t next_data;
		logic       prev_ge;

		if (i == 0) begin : g_head
			assign prev_data = '0;
			assign prev_ge   = 1'b1;
		end else begin : g_body
			assign prev_data = data[i-1];
			assign prev_ge   = ge[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign next_data = data[i];
		end else begin : g_inner
			assign next_data = data[i+1];
		end

		ipq_cell u_cell (
			.clk       (clk),
			.index     (POS_W'(i)),
			.cmd       (cmd),
			.prev_data (prev_data),
			.prev_ge   (prev_ge),
			.next_data (next_data),
			.data      (data[i]),
			.ge        (ge[i]),
			.match     (match[i])
		);
	end

	// ids are unique, so or-ing the matching cell's fields selects it
	always_comb begin
		loc.pos      = '0;
		loc.key      = '0;
		loc.head_id  = data[0].id;
		loc.head_key = data[0].key;
		for (int i = 0; i < CAPACITY; i++) begin
			if (match[i]) begin
				loc.pos = loc.pos | POS_W'(i);
				loc.key = loc.key | data[i].key;
			end
		end
	end

	a_unique_id: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match))
		else $error("more than one cell holds the same id");

	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == CELL_INSERT) |-> (cmd.count < CNT_W'(CAPACITY)))
		else $error("insert shift issued on a full list");

	a_busy_shift: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op != CELL_HOLD) |-> !req.ready)
		else $error("cells shifting while a new transaction can be taken");

endmodule

// ===== rtl/core/ipq_cell.sv =====
// ipq_cell: one slot of the sorted list; holds id and key, shifts with its neighbors
// depends on ipq_pkg
module ipq_cell (
	input  logic                  clk,
	input  logic [ipq_pkg::POS_W-1:0] index,
	input  ipq_pkg::cell_cmd_t    cmd,
	input  ipq_pkg::cell_data_t   prev_data,
	input  logic                  prev_ge,
	input  ipq_pkg::cell_data_t   next_data,
	output ipq_pkg::cell_data_t   data,
	output logic                  ge,
	output logic                  match
);
	import ipq_pkg::*;

	cell_data_t data_q;
	cell_data_t new_data;
	logic       occupied;

	assign occupied = CNT_W'(index) < cmd.count;
	assign ge       = occupied && (data_q.key >= cmd.key);
	assign match    = occupied && (data_q.id == cmd.id);
	assign data     = data_q;

	always_comb begin
		new_data.id  = cmd.id;
		new_data.key = cmd.key;
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			CELL_HOLD: begin
			end
			CELL_INSERT: begin
				if (!ge) begin
					data_q <= prev_ge ? new_data : prev_data;
				end
			end
			CELL_REMOVE: begin
				if (index >= cmd.pos) begin
					data_q <= next_data;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/core/ipq_ctrl.sv =====
// ipq_ctrl: operation sequencer, id map, entry count, limit register and result register
// depends on ipq_pkg, ipq_req_if, ipq_rsp_if
module ipq_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [ipq_pkg::LIMIT_W-1:0] cfg_wdata,
	ipq_req_if.sink                     req,
	ipq_rsp_if.source                   rsp,
	input  ipq_pkg::loc_t               loc,
	output ipq_pkg::cell_cmd_t          cmd
);
	import ipq_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_CHANGE,
		ST_REINSERT
	} state_t;

	state_t                  state_q;
	logic [OP_W-1:0]         op_q;
	logic [ID_W-1:0]         id_q;
	logic signed [KEY_W-1:0] key_q;
	logic                    valid_q;
	logic                    here_q;
	logic [CNT_W-1:0]        count_q;
	logic [ID_SPACE-1:0]     present_q;
	logic [LIMIT_W-1:0]      limit_q;
	logic [POS_W-1:0]        pos_q;
	logic signed [KEY_W-1:0] old_key_q;
	logic                    out_valid_q;
	logic                    ok_q;
	logic [ID_W-1:0]         oid_q;
	logic signed [KEY_W-1:0] opri_q;
	logic [CNT_W-1:0]        ocount_q;

	logic accept;
	logic id_valid;
	logic ins_ok;
	logic better;
	logic empty;

	assign req.ready = (state_q == ST_IDLE) && (!out_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;
	assign id_valid  = LIMIT_W'(req.entry_id) < limit_q;
	assign ins_ok    = valid_q && !here_q && (count_q != CNT_W'(CAPACITY));
	assign empty     = (count_q == '0);
	assign better    = (op_q == OP_INCREASE) ? (key_q > old_key_q) : (key_q < old_key_q);

	assign rsp.valid        = out_valid_q;
	assign rsp.ok           = ok_q;
	assign rsp.out_id       = oid_q;
	assign rsp.out_priority = opri_q;
	assign rsp.count        = ocount_q;

	always_comb begin
		cmd.op    = CELL_HOLD;
		cmd.pos   = pos_q;
		cmd.id    = id_q;
		cmd.key   = key_q;
		cmd.count = count_q;
		unique case (state_q)
			ST_IDLE: begin
			end
			ST_DECIDE: begin
				if (op_q == OP_INSERT && ins_ok) begin
					cmd.op = CELL_INSERT;
				end else if (op_q == OP_REMOVE_MAX && !empty) begin
					cmd.op  = CELL_REMOVE;
					cmd.pos = '0;
				end
			end
			ST_CHANGE: begin
				if (better) begin
					cmd.op = CELL_REMOVE;
				end
			end
			ST_REINSERT: begin
				cmd.op = CELL_INSERT;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			present_q   <= '0;
			limit_q     <= LIMIT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q    <= req.op;
						id_q    <= req.entry_id;
						key_q   <= req.priority_req;
						valid_q <= id_valid;
						here_q  <= id_valid && present_q[req.entry_id];
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					state_q     <= ST_IDLE;
					out_valid_q <= 1'b1;
					ok_q        <= 1'b0;
					oid_q       <= id_q;
					opri_q      <= '0;
					ocount_q    <= count_q;
					unique case (op_q)
						OP_INSERT: begin
							if (ins_ok) begin
								count_q         <= count_q + 1'b1;
								present_q[id_q] <= 1'b1;
								ok_q            <= 1'b1;
								ocount_q        <= count_q + 1'b1;
							end
						end
						OP_INCREASE, OP_DECREASE: begin
							if (here_q) begin
								pos_q       <= loc.pos;
								old_key_q   <= loc.key;
								out_valid_q <= 1'b0;
								state_q     <= ST_CHANGE;
							end
						end
						OP_REMOVE_MAX: begin
							oid_q <= '0;
							if (!empty) begin
								count_q                <= count_q - 1'b1;
								present_q[loc.head_id] <= 1'b0;
								ok_q                   <= 1'b1;
								oid_q                  <= loc.head_id;
								opri_q                 <= loc.head_key;
								ocount_q               <= count_q - 1'b1;
							end
						end
						OP_QUERY: begin
							if (here_q) begin
								ok_q   <= 1'b1;
								opri_q <= loc.key;
							end
						end
						default: begin
						end
					endcase
				end
				ST_CHANGE: begin
					if (better) begin
						count_q <= count_q - 1'b1;
						state_q <= ST_REINSERT;
					end else begin
						out_valid_q <= 1'b1;
						ok_q        <= 1'b0;
						oid_q       <= id_q;
						opri_q      <= '0;
						ocount_q    <= count_q;
						state_q     <= ST_IDLE;
					end
				end
				ST_REINSERT: begin
					count_q     <= count_q + 1'b1;
					out_valid_q <= 1'b1;
					ok_q        <= 1'b1;
					oid_q       <= id_q;
					opri_q      <= '0;
					ocount_q    <= count_q + 1'b1;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== tb/indexed_priority_queue_top_test.sv =====
// indexed_priority_queue_top_test: self-checking bench for indexed_priority_queue_top
// a sorted-list predictor in a small scoreboard class checks every result transaction
// depends on ipq_pkg, ipq_req_if, ipq_rsp_if and the queue rtl
module indexed_priority_queue_top_test;
	import ipq_pkg::*;

	localparam int LONG_HOLD_CYCLES = 300;
	localparam int WATCHDOG_LIMIT   = 2000;
	localparam int SETTLE_CYCLES    = 8;
	localparam logic [OP_W-1:0] OP_RESERVED_LO = 3'd5;
	localparam logic [OP_W-1:0] OP_RESERVED_HI = 3'd7;

	typedef struct packed {
		logic                    ok;
		logic [ID_W-1:0]         out_id;
		logic signed [KEY_W-1:0] out_priority;
		logic [CNT_W-1:0]        count;
	} result_t;

	class queue_scoreboard;
		logic [ID_W-1:0]         list_id[CAPACITY];
		logic signed [KEY_W-1:0] list_key[CAPACITY];
		bit                      id_held[ID_SPACE];
		int                      held;
		logic [LIMIT_W-1:0]      id_limit;
		result_t                 pending_results[$];
		int                      errors;

		function new();
			held = 0;
			id_limit = LIMIT_RESET;
			errors = 0;
			foreach (id_held[i]) id_held[i] = 1'b0;
		endfunction

		function int locate(logic [ID_W-1:0] id);
			for (int i = 0; i < held; i++)
				if (list_id[i] == id) return i;
			return held;
		endfunction

		function void take_out(int pos);
			for (int i = pos; i + 1 < held; i++) begin
				list_id[i] = list_id[i + 1];
				list_key[i] = list_key[i + 1];
			end
			held--;
		endfunction

		// new or moved entries go behind all entries of equal or higher priority
		function void place_entry(logic [ID_W-1:0] id, logic signed [KEY_W-1:0] key);
			int pos;
			pos = 0;
			while (pos < held && list_key[pos] >= key)
				pos++;
			for (int i = held; i > pos; i--) begin
				list_id[i] = list_id[i - 1];
				list_key[i] = list_key[i - 1];
			end
			list_id[pos] = id;
			list_key[pos] = key;
			held++;
		endfunction

		function void note_request(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
				logic signed [KEY_W-1:0] key);
			result_t r;
			int      lim;
			int      pos;
			bit      in_range;
			bit      here;
			lim = (id_limit > ID_SPACE) ? ID_SPACE : id_limit;
			in_range = id < lim;
			here = in_range && id_held[id];
			r.ok = 1'b0;
			r.out_id = id;
			r.out_priority = '0;
			case (op)
				OP_INSERT: begin
					if (in_range && !here && held < CAPACITY) begin
						place_entry(id, key);
						id_held[id] = 1'b1;
						r.ok = 1'b1;
					end
				end
				OP_INCREASE, OP_DECREASE: begin
					if (here) begin
						pos = locate(id);
						if ((op == OP_INCREASE) ? key > list_key[pos] : key < list_key[pos]) begin
							take_out(pos);
							place_entry(id, key);
							r.ok = 1'b1;
						end
					end
				end
				OP_REMOVE_MAX: begin
					r.out_id = '0;
					if (held > 0) begin
						r.out_id = list_id[0];
						r.out_priority = list_key[0];
						id_held[list_id[0]] = 1'b0;
						take_out(0);
						r.ok = 1'b1;
					end
				end
				OP_QUERY: begin
					if (here) begin
						r.out_priority = list_key[locate(id)];
						r.ok = 1'b1;
					end
				end
				default: ;
			endcase
			r.count = CNT_W'(held);
			pending_results.push_back(r);
		endfunction

		function void check_result(logic ok, logic [ID_W-1:0] out_id,
				logic signed [KEY_W-1:0] out_priority, logic [CNT_W-1:0] count);
			result_t want;
			if (pending_results.size() == 0) begin
				$error("result transaction with no request outstanding");
				errors++;
				return;
			end
			want = pending_results.pop_front();
			if (ok !== want.ok) begin
				$error("ok: expected %0d, actual %0d", want.ok, ok);
				errors++;
			end
			if (out_id !== want.out_id) begin
				$error("out_id: expected %0d, actual %0d", want.out_id, out_id);
				errors++;
			end
			if (out_priority !== want.out_priority) begin
				$error("out_priority: expected %0d, actual %0d", want.out_priority, out_priority);
				errors++;
			end
			if (count !== want.count) begin
				$error("count: expected %0d, actual %0d", want.count, count);
				errors++;
			end
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		// leaves id and key untouched when the list is empty
		function bit pick_entry(inout logic [ID_W-1:0] id, inout logic signed [KEY_W-1:0] key);
			int pos;
			if (held == 0) return 1'b0;
			pos = $urandom_range(0, held - 1);
			id = list_id[pos];
			key = list_key[pos];
			return 1'b1;
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic [LIMIT_W-1:0] cfg_wdata;
	bit                 tx_idle_en;
	bit                 rx_idle_en;
	bit                 rsp_hold_req;
	int                 stuck_cycles;
	queue_scoreboard    scoreboard;

	ipq_req_if req_ch();
	ipq_rsp_if rsp_ch();

	indexed_priority_queue_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (req_ch.valid && req_ch.ready)
			scoreboard.note_request(req_ch.op, req_ch.entry_id, req_ch.priority_req);
		if (rsp_ch.valid && rsp_ch.ready)
			scoreboard.check_result(rsp_ch.ok, rsp_ch.out_id, rsp_ch.out_priority, rsp_ch.count);
	end

	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			stuck_cycles <= 0;
		else if (stuck_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else
			stuck_cycles <= stuck_cycles + 1;
	end

	// result receiver: random stall bursts, plus one long hold-off on request
	initial begin
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (rsp_hold_req) begin
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
				rsp_hold_req = 1'b0;
			end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
		end
	end

	task automatic issue_op(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
			input logic signed [KEY_W-1:0] key);
		if (tx_idle_en && $urandom_range(0, 4) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.op <= op;
		req_ch.entry_id <= id;
		req_ch.priority_req <= key;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	task automatic wait_for_results();
		req_ch.valid <= 1'b0;
		while (scoreboard.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_id_limit(input logic [LIMIT_W-1:0] value);
		wait_for_results();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		scoreboard.id_limit = value;
	endtask

	// ties and extremes are common on purpose
	function automatic logic signed [KEY_W-1:0] pick_priority();
		case ($urandom_range(0, 7))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return '0;
			3, 4: return KEY_W'((int'($urandom_range(0, 15)) - 8) * 65536);
			default: return KEY_W'($urandom);
		endcase
	endfunction

	task automatic run_phase(input int items, input int w_insert, input int w_change,
			input int w_remove, input int w_query, input int id_hi);
		logic [OP_W-1:0]         op;
		logic [ID_W-1:0]         id;
		logic signed [KEY_W-1:0] key;
		logic signed [KEY_W-1:0] old_key;
		int                      roll;
		repeat (items) begin
			roll = $urandom_range(0, w_insert + w_change + w_remove + w_query);
			id = ID_W'($urandom_range(0, id_hi));
			key = pick_priority();
			if (roll < w_insert)
				op = OP_INSERT;
			else if (roll < w_insert + w_change) begin
				op = $urandom_range(0, 1) ? OP_INCREASE : OP_DECREASE;
				if ($urandom_range(0, 4) != 0 && scoreboard.pick_entry(id, old_key)) begin
					case ($urandom_range(0, 5))
						0: key = old_key;
						1: key = old_key + 1;
						2: key = old_key - 1;
						3: key = (op == OP_INCREASE) ? old_key + KEY_W'($urandom_range(1, 1 << 20))
							: old_key - KEY_W'($urandom_range(1, 1 << 20));
						4: key = (op == OP_INCREASE) ? old_key - 65536 : old_key + 65536;
						default: ;
					endcase
				end
			end else if (roll < w_insert + w_change + w_remove)
				op = OP_REMOVE_MAX;
			else if (roll < w_insert + w_change + w_remove + w_query) begin
				op = OP_QUERY;
				if ($urandom_range(0, 9) < 7)
					void'(scoreboard.pick_entry(id, old_key));
			end else
				op = OP_W'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI));
			issue_op(op, id, key);
		end
	endtask

	initial begin
		scoreboard = new();
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		req_ch.valid <= 1'b0;
		req_ch.op <= OP_INSERT;
		req_ch.entry_id <= '0;
		req_ch.priority_req <= '0;
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		rsp_hold_req = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue and missing ids
		issue_op(OP_REMOVE_MAX, 6'd0, '0);
		issue_op(OP_QUERY, 6'd5, '0);
		issue_op(OP_INCREASE, 6'd5, 32'sd65536);
		// extremes, duplicate insert, equal priorities
		issue_op(OP_INSERT, 6'd0, 32'sh7FFF_FFFF);
		issue_op(OP_INSERT, 6'd63, 32'sh8000_0000);
		issue_op(OP_INSERT, 6'd0, 32'sd5);
		issue_op(OP_INSERT, 6'd10, '0);
		issue_op(OP_INSERT, 6'd11, '0);
		// no change in priority is rejected both ways
		issue_op(OP_INCREASE, 6'd11, '0);
		issue_op(OP_DECREASE, 6'd11, '0);
		issue_op(OP_INCREASE, 6'd11, 32'sd1);
		issue_op(OP_DECREASE, 6'd10, -32'sd65536);
		issue_op(OP_QUERY, 6'd63, '0);
		issue_op(OP_QUERY, 6'd10, '0);
		issue_op(OP_RESERVED_LO, 6'd10, 32'sd7);
		issue_op(OP_RESERVED_HI, 6'd63, -32'sd1);
		// moved entry lands behind an equal head
		issue_op(OP_INCREASE, 6'd63, 32'sh7FFF_FFFF);
		repeat (5) issue_op(OP_REMOVE_MAX, 6'd63, '0);

		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		set_id_limit(7'd64);
		rsp_hold_req = 1'b1;
		run_phase(400, 40, 10, 4, 6, 63);

		rx_idle_en = 1'b0;
		set_id_limit(7'd127);
		run_phase(350, 15, 25, 10, 10, 63);

		// lowered limit strands held entries that only remove_max can reach
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b1;
		set_id_limit(7'd8);
		run_phase(250, 15, 15, 15, 10, 15);

		rx_idle_en = 1'b0;
		set_id_limit(7'd0);
		run_phase(100, 15, 10, 10, 10, 63);

		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		set_id_limit(7'd1);
		run_phase(150, 20, 15, 15, 10, 3);

		set_id_limit(LIMIT_W'($urandom_range(2, 63)));
		run_phase(330, 20, 20, 12, 10, 63);

		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		set_id_limit(7'd64);
		run_phase(250, 8, 10, 25, 7, 63);

		wait_for_results();
		if (scoreboard.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
